### sv/pwbm_pkg.sv
// Package for the part-in-whole box matcher.
// Holds sizes, the stored box type, register indexes and the class map lookup.
// Used by every module of the block; depends on nothing else.
package pwbm_pkg;

	localparam int MAX_BOXES    = 16;
	localparam int COORD_BITS   = 12;
	localparam int RESULT_LIMIT = 64;

	localparam int CNT_W = $clog2(MAX_BOXES + 1);
	localparam int IDX_W = $clog2(MAX_BOXES);
	localparam int RES_W = $clog2(RESULT_LIMIT + 1);

	localparam logic [7:0] NO_PART = 8'hFF;

	typedef enum logic [1:0] {
		REG_WHOLE_CLASS = 2'd0,
		REG_MAP_LOW     = 2'd1,
		REG_MAP_HIGH    = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [3:0]            cls;
		logic [COORD_BITS-1:0] x1;
		logic [COORD_BITS-1:0] y1;
		logic [COORD_BITS-1:0] x2;
		logic [COORD_BITS-1:0] y2;
	} box_t;

	// Object id of a detector class; byte k of the 128-bit map serves class k.
	function automatic logic [7:0] map_class(input logic [3:0] cls, input logic [63:0] lo,
			input logic [63:0] hi);
		logic [127:0] m;
		m = {hi, lo};
		return m[{cls, 3'b000} +: 8];
	endfunction

endpackage

### sv/part_in_whole_box_matcher.sv
// Top level of the part-in-whole box matcher.
// Holds the box store, the match sequencer and the output register.
// Depends on pwbm_pkg.

// The block collects one frame of detector boxes, one transaction per cycle, until a
// box with frame_end set arrives; boxes past MAX_BOXES in a frame are dropped, but a
// dropped box carrying frame_end still starts matching. It then walks every stored
// whole box (class equal to whole_class) in arrival order, and for each one walks all
// stored boxes in arrival order through one shared compare unit, which checks a single
// candidate per step: the class must differ from whole_class, map to an id other than
// 255, and the box must lie fully inside the whole box. Each hit gives one result with
// the id and the floored centre of the whole box; the last result of a frame carries
// run_last, and a frame with no hits gives one result with found cleared. At most 64
// results are given per frame. The box store has a single registered read port, so
// every visited box passes first through a read state and then a check state; matching
// stalls when a result is to be loaded while the result consumer holds out_ready low.
// In_ready is low during matching and high again once the final result of the frame
// has been placed in the output register, so the next frame can be collected while
// that result still waits to be taken. Configuration writes are accepted in every
// cycle and must only be made while the block is idle.
module part_in_whole_box_matcher
	import pwbm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [1:0]            cfg_index,
	input  logic [63:0]           cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [3:0]            box_class,
	input  logic [COORD_BITS-1:0] left_x,
	input  logic [COORD_BITS-1:0] top_y,
	input  logic [COORD_BITS-1:0] right_x,
	input  logic [COORD_BITS-1:0] bottom_y,
	input  logic                  frame_end,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  found,
	output logic [7:0]            object_id,
	output logic [COORD_BITS-1:0] centre_x,
	output logic [COORD_BITS-1:0] centre_y,
	output logic                  run_last
);

	typedef enum logic [2:0] {
		S_COLLECT,
		S_WREAD,
		S_WCHK,
		S_PREAD,
		S_PCHK,
		S_FINISH
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [3:0]  wc_q;
	logic [63:0] map_lo_q;
	logic [63:0] map_hi_q;

	// Box store and its registered read port.
	box_t            box_mem_q [MAX_BOXES];
	box_t            rd_q;
	logic            rd_en;
	logic [IDX_W-1:0] rd_addr;

	// Walk counters: whole box index, candidate index, results found so far.
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] i_q;
	logic [CNT_W-1:0] j_q;
	logic [RES_W-1:0] n_q;

	// The current whole box and its centre.
	box_t                  w_q;
	logic [COORD_BITS-1:0] cx_q;
	logic [COORD_BITS-1:0] cy_q;

	// The most recent hit is held back until it is known whether it is the last.
	logic [7:0]            pend_id_q;
	logic [COORD_BITS-1:0] pend_cx_q;
	logic [COORD_BITS-1:0] pend_cy_q;

	logic out_valid_q;
	logic found_q;
	logic [7:0] object_id_q;
	logic [COORD_BITS-1:0] centre_x_q;
	logic [COORD_BITS-1:0] centre_y_q;
	logic run_last_q;

	logic       in_acc;
	logic       store_room;
	logic       out_free;
	logic       out_load;
	logic [7:0] part_id;
	logic       part_hit;
	logic       have_pend;
	logic [COORD_BITS:0] sum_x;
	logic [COORD_BITS:0] sum_y;
	box_t       in_box;

	assign cfg_ready  = 1'b1;
	assign in_ready   = (state_q == S_COLLECT);
	assign in_acc     = in_valid && in_ready;
	assign store_room = (count_q != CNT_W'(MAX_BOXES));
	assign out_free   = !out_valid_q || out_ready;
	assign have_pend  = (n_q != '0);

	// The output register is loaded when a held hit is released or the frame closes.
	assign out_load = out_free &&
		((state_q == S_PCHK && part_hit && have_pend) || state_q == S_FINISH);

	assign in_box = '{cls: box_class, x1: left_x, y1: top_y, x2: right_x, y2: bottom_y};

	// Shared compare unit: one candidate against the current whole box.
	assign part_id  = map_class(rd_q.cls, map_lo_q, map_hi_q);
	assign part_hit = (rd_q.cls != wc_q) && (part_id != NO_PART) &&
		(rd_q.x1 >= w_q.x1) && (rd_q.x2 <= w_q.x2) &&
		(rd_q.y1 >= w_q.y1) && (rd_q.y2 <= w_q.y2);

	assign sum_x = {1'b0, rd_q.x1} + {1'b0, rd_q.x2};
	assign sum_y = {1'b0, rd_q.y1} + {1'b0, rd_q.y2};

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = i_q[IDX_W-1:0];
		if (state_q == S_WREAD && i_q != count_q) begin
			rd_en = 1'b1;
		end else if (state_q == S_PREAD && j_q != count_q) begin
			rd_en   = 1'b1;
			rd_addr = j_q[IDX_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && store_room) begin
			box_mem_q[count_q[IDX_W-1:0]] <= in_box;
		end
		if (rd_en) begin
			rd_q <= box_mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wc_q <= '0;
			map_lo_q <= '1;
			map_hi_q <= '1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_WHOLE_CLASS: wc_q <= cfg_data[3:0];
				REG_MAP_LOW:     map_lo_q <= cfg_data;
				REG_MAP_HIGH:    map_hi_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_COLLECT;
			count_q     <= '0;
			i_q         <= '0;
			j_q         <= '0;
			n_q         <= '0;
			w_q         <= '0;
			cx_q        <= '0;
			cy_q        <= '0;
			pend_id_q   <= '0;
			pend_cx_q   <= '0;
			pend_cy_q   <= '0;
			out_valid_q <= 1'b0;
			found_q     <= 1'b0;
			object_id_q <= '0;
			centre_x_q  <= '0;
			centre_y_q  <= '0;
			run_last_q  <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_COLLECT: begin
					if (in_acc) begin
						if (store_room) begin
							count_q <= count_q + CNT_W'(1);
						end
						if (frame_end) begin
							i_q     <= '0;
							state_q <= S_WREAD;
						end
					end
				end
				S_WREAD: begin
					state_q <= (i_q == count_q) ? S_FINISH : S_WCHK;
				end
				S_WCHK: begin
					if (rd_q.cls == wc_q) begin
						w_q     <= rd_q;
						cx_q    <= sum_x[COORD_BITS:1];
						cy_q    <= sum_y[COORD_BITS:1];
						j_q     <= '0;
						state_q <= S_PREAD;
					end else begin
						i_q     <= i_q + CNT_W'(1);
						state_q <= S_WREAD;
					end
				end
				S_PREAD: begin
					if (j_q == count_q) begin
						i_q     <= i_q + CNT_W'(1);
						state_q <= S_WREAD;
					end else begin
						state_q <= S_PCHK;
					end
				end
				S_PCHK: begin
					if (!part_hit) begin
						j_q     <= j_q + CNT_W'(1);
						state_q <= S_PREAD;
					end else if (!have_pend || out_free) begin
						// Release the held hit, now known not to be the last one.
						if (have_pend) begin
							found_q     <= 1'b1;
							object_id_q <= pend_id_q;
							centre_x_q  <= pend_cx_q;
							centre_y_q  <= pend_cy_q;
							run_last_q  <= 1'b0;
						end
						pend_id_q <= part_id;
						pend_cx_q <= cx_q;
						pend_cy_q <= cy_q;
						n_q       <= n_q + RES_W'(1);
						j_q       <= j_q + CNT_W'(1);
						// The result limit ends the walk at once.
						state_q   <= (n_q == RES_W'(RESULT_LIMIT - 1)) ? S_FINISH : S_PREAD;
					end
				end
				S_FINISH: begin
					if (out_free) begin
						found_q     <= have_pend;
						object_id_q <= have_pend ? pend_id_q : '0;
						centre_x_q  <= have_pend ? pend_cx_q : '0;
						centre_y_q  <= have_pend ? pend_cy_q : '0;
						run_last_q  <= 1'b1;
						n_q         <= '0;
						count_q     <= '0;
						state_q     <= S_COLLECT;
					end
				end
				default: begin
					state_q <= S_COLLECT;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign found     = found_q;
	assign object_id = object_id_q;
	assign centre_x  = centre_x_q;
	assign centre_y  = centre_y_q;
	assign run_last  = run_last_q;

endmodule

### sv/pwbm_checker.sv
// Port-level checker for the part-in-whole box matcher, with its bind statement.
// Depends on pwbm_pkg and on the top level part_in_whole_box_matcher.
module pwbm_checker
	import pwbm_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  cfg_valid,
	input logic                  cfg_ready,
	input logic [1:0]            cfg_index,
	input logic [63:0]           cfg_data,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic [3:0]            box_class,
	input logic [COORD_BITS-1:0] left_x,
	input logic [COORD_BITS-1:0] top_y,
	input logic [COORD_BITS-1:0] right_x,
	input logic [COORD_BITS-1:0] bottom_y,
	input logic                  frame_end,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic                  found,
	input logic [7:0]            object_id,
	input logic [COORD_BITS-1:0] centre_x,
	input logic [COORD_BITS-1:0] centre_y,
	input logic                  run_last
);

	// An empty-frame marker is always the final result of its frame.
	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> run_last)
		else $error("empty-frame marker without run_last");

	// An empty-frame marker carries all-zero payload.
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> object_id == 8'd0 && centre_x == '0 && centre_y == '0)
		else $error("empty-frame marker with nonzero payload");

	// A matched pair never reports the no-part id.
	a_hit_id: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && found |-> object_id != NO_PART)
		else $error("matched pair reports the no-part id");

	// Matching starts right after the frame's last box, so no box is taken then.
	a_busy_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && frame_end |=> !in_ready)
		else $error("input taken directly after a frame end");

endmodule

bind part_in_whole_box_matcher pwbm_checker u_pwbm_checker (.*);
